// ===== src/sxk_pkg.sv =====
// Shared types, constants and the letter weight table of the XOR key search.
`timescale 1ns / 1ps
`default_nettype none
package sxk_pkg;

  // Design dimensions
  localparam int NUM_KEYS        = 256;
  localparam int SCORE_BITS      = 14;
  localparam int LINE_INDEX_BITS = 16;
  localparam int KEY_BITS        = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int BYTE_BITS       = 8;
  localparam int WEIGHT_BITS     = 4;

  // Port field widths
  localparam int KEY_W   = 8;
  localparam int SCORE_W = 14;
  localparam int LINE_W  = 16;
  localparam int OUT_DATA_BITS = KEY_W + SCORE_W + 1 + LINE_W + LINE_W + KEY_W + SCORE_W;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_DATA_BITS;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [SCORE_BITS-1:0] score_t;
  typedef logic [BYTE_BITS-1:0]  byte_t;

  // Score sweep sequencer states
  typedef enum logic [2:0] {
    SC_CLEAR,
    SC_IDLE,
    SC_SWEEP,
    SC_DRAIN,
    SC_FIN
  } sc_state_t;

  // Job handed to the sweep unit
  typedef struct packed {
    logic  start;
    byte_t cipher;
    logic  line_end;
  } sxk_job_t;

  // Line result returned by the sweep unit
  typedef struct packed {
    logic   done;
    key_t   key;
    score_t score;
  } sxk_res_t;

  // ETAOIN SHRDLU weights, case-insensitive, space weighs 7
  function automatic logic [WEIGHT_BITS-1:0] letter_weight(input byte_t c);
    byte_t lc;
    logic [WEIGHT_BITS-1:0] w;
    lc = c;
    if (c >= 8'h41 && c <= 8'h5A) lc = c | 8'h20;
    case (lc)
      8'h20:   w = 4'd7;
      8'h65:   w = 4'd13;  // e
      8'h74:   w = 4'd12;  // t
      8'h61:   w = 4'd11;  // a
      8'h6F:   w = 4'd10;  // o
      8'h69:   w = 4'd9;   // i
      8'h6E:   w = 4'd8;   // n
      8'h73:   w = 4'd6;   // s
      8'h68:   w = 4'd5;   // h
      8'h72:   w = 4'd4;   // r
      8'h64:   w = 4'd3;   // d
      8'h6C:   w = 4'd2;   // l
      8'h75:   w = 4'd1;   // u
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== src/sxk_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sxk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/sxk_sweep.sv =====
// Per-byte sweep over all key scores: read-modify-write with saturation and argmax.
`timescale 1ns / 1ps
`default_nettype none
module sxk_sweep (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sxk_pkg::sxk_job_t job,
  input  wire logic            res_ready,
  output logic                 ready,
  output sxk_pkg::sxk_res_t    res
);
  import sxk_pkg::*;

  sc_state_t state_r, state_nxt;
  key_t      cnt_r, cnt_nxt;
  logic      p_valid_r, p_valid_nxt;
  key_t      p_key_r, p_key_nxt;
  byte_t     byte_r;
  logic      lend_r;
  key_t      top_key_r, top_key_nxt;
  score_t    top_score_r, top_score_nxt;

  logic      ram_we;
  key_t      ram_waddr;
  score_t    ram_wdata;
  key_t      ram_raddr;
  score_t    ram_rdata;

  logic [SCORE_BITS:0]  sum;
  score_t               sat;
  byte_t                decoded;
  logic                 last_key;

  sxk_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (NUM_KEYS)
  ) u_scores (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Saturating add of the decoded byte's weight
  always_comb begin
    decoded = byte_r ^ BYTE_BITS'(p_key_r);
    sum     = {1'b0, ram_rdata} + (SCORE_BITS + 1)'(letter_weight(decoded));
    sat     = sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];
  end

  assign last_key = (cnt_r == KEY_BITS'(NUM_KEYS - 1));

  // Sequencer, write-back and argmax
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    p_valid_nxt   = 1'b0;
    p_key_nxt     = cnt_r;
    top_key_nxt   = top_key_r;
    top_score_nxt = top_score_r;
    ram_raddr     = cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = p_key_r;
    ram_wdata     = lend_r ? '0 : sat;
    ready         = 1'b0;
    res.done      = 1'b0;
    res.key       = top_key_r;
    res.score     = top_score_r;

    // write back the entry read last cycle; clear it when the line ends
    if (p_valid_r) begin
      ram_we = 1'b1;
      if (lend_r && (sat > top_score_r)) begin
        top_score_nxt = sat;
        top_key_nxt   = p_key_r;
      end
    end

    case (state_r)
      SC_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        if (last_key) begin
          cnt_nxt   = '0;
          state_nxt = SC_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      SC_IDLE: begin
        ready = 1'b1;
        if (job.start) begin
          cnt_nxt       = '0;
          top_key_nxt   = '0;
          top_score_nxt = '0;
          state_nxt     = SC_SWEEP;
        end
      end
      SC_SWEEP: begin
        p_valid_nxt = 1'b1;
        if (last_key) begin
          cnt_nxt   = '0;
          state_nxt = SC_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      SC_DRAIN: begin
        state_nxt = lend_r ? SC_FIN : SC_IDLE;
      end
      SC_FIN: begin
        if (res_ready) begin
          res.done  = 1'b1;
          state_nxt = SC_IDLE;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SC_CLEAR;
      cnt_r     <= '0;
      p_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      p_valid_r <= p_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_key_r     <= p_key_nxt;
    top_key_r   <= top_key_nxt;
    top_score_r <= top_score_nxt;
    if (state_r == SC_IDLE && job.start) begin
      byte_r <= job.cipher;
      lend_r <= job.line_end;
    end
  end

endmodule
`default_nettype wire

// ===== src/single_byte_xor_key_search.sv =====
// Top level of the single-byte XOR key search: stream ports and line bookkeeping.
//
// Usage: ciphertext bytes enter on the in_ stream, one byte per beat; in_tlast
// marks the last byte of a line and in_tuser (taken only with in_tlast) marks
// the file's last line. Each byte is scored against all NUM_KEYS keys by one
// read-modify-write of the score RAM per cycle; in_tready stays low through
// the sweep and its drain step, and for a line-ending byte (with argmax) until
// its result is handed on; the single RAM port pair sets this pace.
// A line-ending byte produces one out_ beat: the line's best key and score,
// and, with out_tuser high, the best line of the file. Other bytes produce none.
// After reset the score RAM is swept to zero, entry by entry, during
// which in_tready stays low. A finished result sits in the output register
// while the next byte is taken; if the receiver holds out_tready low, the
// following line result waits in the sweep unit and input stalls behind it.
`timescale 1ns / 1ps
`default_nettype none
module single_byte_xor_key_search (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // cipher_byte
  input  wire logic                            in_tlast,   // line_end
  input  wire logic                            in_tuser,   // file_end
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // line_key, line_score, line_found, line_number, overall_line, overall_key,
  // overall_score, zero pad
  output logic [sxk_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tuser   // overall_valid
);
  import sxk_pkg::*;

  sxk_job_t job;
  sxk_res_t res;
  logic     sweep_ready;
  logic     res_ready;
  logic     in_fire;

  logic                       file_r;
  logic [LINE_INDEX_BITS-1:0] line_cnt_r;
  score_t                     best_score_r, best_score_nxt;
  logic [LINE_INDEX_BITS-1:0] best_line_r, best_line_nxt;
  key_t                       best_key_r, best_key_nxt;
  logic                       out_valid_r;
  logic [OUT_TDATA_W-1:0]     out_data_r, out_data_nxt;
  logic                       out_user_r;

  assign in_tready = sweep_ready;
  assign in_fire   = in_tvalid && sweep_ready;
  assign res_ready = !out_valid_r || out_tready;

  assign job.start    = in_fire;
  assign job.cipher   = in_tdata;
  assign job.line_end = in_tlast;

  sxk_sweep u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .res_ready (res_ready),
    .ready     (sweep_ready),
    .res       (res)
  );

  // Best line so far, including the line just ended
  always_comb begin
    best_score_nxt = best_score_r;
    best_line_nxt  = best_line_r;
    best_key_nxt   = best_key_r;
    if (res.score > best_score_r) begin
      best_score_nxt = res.score;
      best_line_nxt  = line_cnt_r;
      best_key_nxt   = res.key;
    end
  end

  // Result beat packing
  always_comb begin
    out_data_nxt = {
      {OUT_PAD_W{1'b0}},
      file_r ? SCORE_W'(best_score_nxt) : {SCORE_W{1'b0}},
      file_r ? KEY_W'(best_key_nxt)     : {KEY_W{1'b0}},
      file_r ? LINE_W'(best_line_nxt)   : {LINE_W{1'b0}},
      LINE_W'(line_cnt_r),
      |res.score,
      SCORE_W'(res.score),
      KEY_W'(res.key)
    };
  end

  // Line bookkeeping and output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r   <= '0;
      best_score_r <= '0;
      best_line_r  <= '0;
      best_key_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (res.done) begin
        out_valid_r <= 1'b1;
        if (file_r) begin
          line_cnt_r   <= '0;
          best_score_r <= '0;
          best_line_r  <= '0;
          best_key_r   <= '0;
        end else begin
          line_cnt_r   <= line_cnt_r + 1'b1;
          best_score_r <= best_score_nxt;
          best_line_r  <= best_line_nxt;
          best_key_r   <= best_key_nxt;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      file_r <= in_tlast && in_tuser;
    end
    if (res.done) begin
      out_data_r <= out_data_nxt;
      out_user_r <= file_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire
